@@ rtl/ir_pulse_pattern_hash_defines.svh @@
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash_defines
// assertion macros used by the pulse pattern hash top level
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_PATTERN_HASH_DEFINES_SVH
`define IR_PULSE_PATTERN_HASH_DEFINES_SVH

// checked only while out of reset
`define IPPH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define IPPH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ipph_pkg.sv @@
// ----------------------------------------------------------------------------
// ipph_pkg
// types and constants of the pulse pattern hash
// ----------------------------------------------------------------------------
package ipph_pkg;

    localparam int DURATION_BITS_DEF = 16;
    localparam int HASH_BITS         = 32;
    localparam int COUNT_BITS        = 3;

    localparam logic [HASH_BITS-1:0] HASH_PRIME = 32'd16777619;
    localparam logic [HASH_BITS-1:0] HASH_BASIS = 32'd2166136261;

    localparam logic [COUNT_BITS-1:0] MIN_SAMPLES    = 3'd6;
    localparam logic [COUNT_BITS-1:0] FIRST_COMPARED = 3'd3;

    // power of two, pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMP_SHORTER = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_LONGER  = 2'd2
    } cmp_code_t;

    typedef struct packed {
        cmp_code_t code;
        logic      do_hash;
        logic      last;
        logic      enough;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ rtl/ipph_front.sv @@
// ----------------------------------------------------------------------------
// ipph_front
// accepts durations, keeps the two previous ones and classifies each
// ----------------------------------------------------------------------------
module ipph_front #(
    parameter int DURATION_BITS = ipph_pkg::DURATION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [DURATION_BITS-1:0]      duration,
    input  logic                          last_sample,
    input  ipph_pkg::queue_status_t       q_status,
    output logic                          push,
    output ipph_pkg::entry_t              push_entry
);

    localparam int PROD_W = DURATION_BITS + 3;

    logic [DURATION_BITS-1:0]        previous_reg;
    logic [DURATION_BITS-1:0]        older_reg;
    logic [ipph_pkg::COUNT_BITS-1:0] count_reg;
    logic [ipph_pkg::COUNT_BITS-1:0] count_next;
    logic [PROD_W-1:0]               new_x5;
    logic [PROD_W-1:0]               new_x4;
    logic [PROD_W-1:0]               old_x5;
    logic [PROD_W-1:0]               old_x4;
    ipph_pkg::cmp_code_t             code;

    assign sample_stall = q_status.full;
    assign push         = sample_valid && !sample_stall;

    assign new_x4 = {1'b0, duration, 2'b00};
    assign new_x5 = new_x4 + PROD_W'(duration);
    assign old_x4 = {1'b0, older_reg, 2'b00};
    assign old_x5 = old_x4 + PROD_W'(older_reg);

    // equal within 4/5 to 5/4 of the older duration, exact in integers
    always_comb
    begin
        if (new_x5 < old_x4)
        begin
            code = ipph_pkg::CMP_SHORTER;
        end
        else if (old_x5 < new_x4)
        begin
            code = ipph_pkg::CMP_LONGER;
        end
        else
        begin
            code = ipph_pkg::CMP_EQUAL;
        end
    end

    assign count_next = (count_reg < ipph_pkg::MIN_SAMPLES) ?
                        count_reg + 3'd1 : count_reg;

    always_comb
    begin
        push_entry.code    = code;
        push_entry.do_hash = (count_reg >= ipph_pkg::FIRST_COMPARED);
        push_entry.last    = last_sample;
        push_entry.enough  = (count_next >= ipph_pkg::MIN_SAMPLES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_reg <= '0;
            older_reg    <= '0;
            count_reg    <= '0;
        end
        else if (push)
        begin
            if (last_sample)
            begin
                previous_reg <= '0;
                older_reg    <= '0;
                count_reg    <= '0;
            end
            else
            begin
                previous_reg <= duration;
                older_reg    <= previous_reg;
                count_reg    <= count_next;
            end
        end
    end

endmodule

@@ rtl/ipph_queue.sv @@
// ----------------------------------------------------------------------------
// ipph_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module ipph_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ipph_pkg::entry_t        push_entry,
    input  logic                    pop,
    output ipph_pkg::entry_t        head,
    output ipph_pkg::queue_status_t status
);

    ipph_pkg::entry_t                 mem [ipph_pkg::QUEUE_DEPTH];
    logic [ipph_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [ipph_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [ipph_pkg::QUEUE_CNT_W-1:0] count_reg;

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == ipph_pkg::QUEUE_CNT_W'(ipph_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/ipph_back.sv @@
// ----------------------------------------------------------------------------
// ipph_back
// folds comparison codes into the running hash and holds the result
// ----------------------------------------------------------------------------
module ipph_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ipph_pkg::entry_t                      head,
    input  ipph_pkg::queue_status_t               q_status,
    output logic                                  pop,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [ipph_pkg::HASH_BITS-1:0]        hash_value,
    output logic                                  hash_valid
);

    logic [ipph_pkg::HASH_BITS-1:0] hash_reg;
    logic [ipph_pkg::HASH_BITS-1:0] hash_mul;
    logic [ipph_pkg::HASH_BITS-1:0] hash_next;
    logic                           result_valid_reg;
    logic [ipph_pkg::HASH_BITS-1:0] hash_value_reg;
    logic                           hash_valid_reg;
    logic                           slot_free;

    assign slot_free = !result_valid_reg || !result_stall;
    // a frame end waits only for the result register
    assign pop       = !q_status.empty && (!head.last || slot_free);

    assign hash_mul  = hash_reg * ipph_pkg::HASH_PRIME;
    assign hash_next = head.do_hash ?
                       (hash_mul ^ {{(ipph_pkg::HASH_BITS-2){1'b0}}, head.code}) :
                       hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg         <= ipph_pkg::HASH_BASIS;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && head.last)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                if (head.last)
                begin
                    hash_reg <= ipph_pkg::HASH_BASIS;
                end
                else
                begin
                    hash_reg <= hash_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            hash_value_reg <= head.enough ? hash_next : '0;
            hash_valid_reg <= head.enough;
        end
    end

    assign result_valid = result_valid_reg;
    assign hash_value   = hash_value_reg;
    assign hash_valid   = hash_valid_reg;

endmodule

@@ rtl/ir_pulse_pattern_hash.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash
// hash of the shorter / equal / longer pattern of one infrared frame
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------
//  sample   | sample_valid / sample_stall  | duration, last_sample
//  result   | result_valid / result_stall  | hash_value, hash_valid
//
//  one duration per cycle unless stalled; front classifies and queues it, back
//  folds one code per cycle into the hash with a constant multiply and xor
//  a frame end passes through the queue and result register to result_valid
//  sample_stall rises only when the two-entry queue is full
//  a stalled result holds the queue only while a frame end is at its head
//  reset clears the queue, the frame state and the hash to its basis
`include "ir_pulse_pattern_hash_defines.svh"

module ir_pulse_pattern_hash #(
    parameter int DURATION_BITS = ipph_pkg::DURATION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  logic [DURATION_BITS-1:0]       duration,
    input  logic                           last_sample,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [ipph_pkg::HASH_BITS-1:0] hash_value,
    output logic                           hash_valid
);

    logic                    push;
    logic                    pop;
    ipph_pkg::entry_t        push_entry;
    ipph_pkg::entry_t        head;
    ipph_pkg::queue_status_t q_status;

    ipph_front #(
        .DURATION_BITS (DURATION_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .duration     (duration),
        .last_sample  (last_sample),
        .q_status     (q_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    ipph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    ipph_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_value   (hash_value),
        .hash_valid   (hash_valid)
    );

    `IPPH_ASSERT(a_short_frame_zero, (result_valid && !hash_valid) |-> (hash_value == '0), "short frame result must carry zero hash")
    `IPPH_ASSERT(a_no_overwrite, (pop && head.last) |-> (!result_valid || !result_stall), "frame end popped over a held result")
    `IPPH_ASSERT(a_no_pop_empty, pop |-> !q_status.empty, "pop from empty queue")
    `IPPH_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!result_valid && !sample_stall), "outputs active in reset")

endmodule

@@ test/ir_pulse_pattern_hash_monitor.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash_monitor
// watches both channels, predicts the frame hash and compares each result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_pulse_pattern_hash_monitor
    import ipph_pkg::*;
#(
    parameter int DURATION_BITS = DURATION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     sample_valid,
    input  logic                     sample_stall,
    input  logic [DURATION_BITS-1:0] duration,
    input  logic                     last_sample,
    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic [HASH_BITS-1:0]     hash_value,
    input  logic                     hash_valid,
    output int                       mismatches,
    output int                       open_results
);

    typedef struct packed {
        logic [HASH_BITS-1:0] hash;
        logic                 valid;
    } frame_result_t;

    frame_result_t frame_results_q[$];

    logic [DURATION_BITS-1:0] prev_dur;
    logic [DURATION_BITS-1:0] two_back_dur;
    logic [COUNT_BITS-1:0]    seen;
    logic [HASH_BITS-1:0]     hash_acc;
    int                       fails = 0;

    function automatic cmp_code_t classify_duration(
        input logic [DURATION_BITS-1:0] was,
        input logic [DURATION_BITS-1:0] now
    );
        longint unsigned o;
        longint unsigned n;
        o = was;
        n = now;
        if (5 * n < 4 * o)
            return CMP_SHORTER;
        if (5 * o < 4 * n)
            return CMP_LONGER;
        return CMP_EQUAL;
    endfunction

    task automatic clear_frame();
        prev_dur     = '0;
        two_back_dur = '0;
        seen         = '0;
        hash_acc     = HASH_BASIS;
    endtask

    task automatic report(input string what, input longint want, input longint got);
        fails++;
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    endtask

    task automatic fold_duration(input logic [DURATION_BITS-1:0] dur, input logic closes);
        frame_result_t res;
        // the leading gap and its two followers only seed the history
        if (seen >= FIRST_COMPARED)
            hash_acc = (hash_acc * HASH_PRIME) ^ HASH_BITS'(classify_duration(two_back_dur, dur));
        two_back_dur = prev_dur;
        prev_dur     = dur;
        if (seen < MIN_SAMPLES)
            seen = seen + 1'b1;
        if (closes)
        begin
            res.valid = (seen >= MIN_SAMPLES);
            res.hash  = res.valid ? hash_acc : '0;
            frame_results_q.push_back(res);
            clear_frame();
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (frame_results_q.size() == 0)
        begin
            report("result with no frame closed", 0, hash_value);
        end
        else
        begin
            want = frame_results_q.pop_front();
            if (hash_value !== want.hash)
                report("hash_value", want.hash, hash_value);
            if (hash_valid !== want.valid)
                report("hash_valid", want.valid, hash_valid);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            frame_results_q.delete();
            open_results <= 0;
        end
        else
        begin
            // a result never belongs to a request taken at the same edge
            if (result_valid && !result_stall)
                check_result();
            if (sample_valid && !sample_stall)
                fold_duration(duration, last_sample);
            open_results <= frame_results_q.size();
        end
        mismatches <= fails;
    end

endmodule

@@ test/ir_pulse_pattern_hash_tb.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash_tb
// frame stimulus with random gaps and stalls, verdict from the monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ir_pulse_pattern_hash_tb;

    import ipph_pkg::*;

    localparam int     DUR_W          = DURATION_BITS_DEF;
    localparam int     DUR_MAX        = (1 << DUR_W) - 1;
    localparam int     RANDOM_SAMPLES = 850;
    localparam int     QUIET_TAIL     = 120;
    localparam int     DIRECTED_LEN   = 25;
    localparam longint CYCLE_LIMIT    = 400000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             sample_valid = 1'b0;
    logic [DUR_W-1:0] duration     = '0;
    logic             last_sample  = 1'b0;
    logic             result_stall = 1'b0;

    logic                 sample_stall;
    logic                 result_valid;
    logic [HASH_BITS-1:0] hash_value;
    logic                 hash_valid;

    int     mismatches;
    int     open_results;
    bit     sender_gaps     = 1'b0;
    bit     receiver_stalls = 1'b0;
    longint cycle_count     = 0;
    int     sent            = 0;

    // short frames, a frame with tolerance edges and extremes, all-zero
    // frame of exactly six, longer-side edge frame
    int directed_durs[DIRECTED_LEN] = '{
        65535,
        0, 100, 200, 100, 300,
        65535, 500, 400, 400, 319, 0, 65535,
        0, 0, 0, 0, 0, 0,
        9, 4000, 7, 5001, 7, 5000
    };
    bit directed_ends[DIRECTED_LEN] = '{
        1,
        0, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 1
    };

    ir_pulse_pattern_hash #(
        .DURATION_BITS (DUR_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .duration     (duration),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_value   (hash_value),
        .hash_valid   (hash_valid)
    );

    ir_pulse_pattern_hash_monitor #(
        .DURATION_BITS (DUR_W)
    ) u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .duration     (duration),
        .last_sample  (last_sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hash_value   (hash_value),
        .hash_valid   (hash_valid),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // receiver stall bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (receiver_stalls && $urandom_range(0, 4) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // stall is sampled at the falling edge, inputs only move at the rising one
    task automatic send_sample(input logic [DUR_W-1:0] dur, input logic closes);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        duration     <= dur;
        last_sample  <= closes;
        @(negedge clk);
        while (sample_stall)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(negedge clk);
        while (open_results != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // new duration placed against the one two back: near, shorter, longer,
    // right at the edges of the equal band, or anywhere
    function automatic logic [DUR_W-1:0] pick_duration(input int paired);
        int v;
        case ($urandom_range(0, 11))
            0, 1:    v = int'($urandom_range(0, DUR_MAX));
            2:       v = $urandom_range(0, 1) ? DUR_MAX : int'($urandom_range(0, 3));
            3, 4, 5: v = paired * int'($urandom_range(80, 125)) / 100;
            6, 7:    v = paired * int'($urandom_range(0, 79)) / 100;
            8, 9:    v = paired * int'($urandom_range(126, 300)) / 100
                         + int'($urandom_range(0, 2));
            10:      v = paired * 4 / 5 + int'($urandom_range(0, 2)) - 1;
            default: v = paired * 5 / 4 + int'($urandom_range(0, 2)) - 1;
        endcase
        if (v < 0)
            v = 0;
        if (v > DUR_MAX)
            v = DUR_MAX;
        return DUR_W'(v);
    endfunction

    function automatic int pick_frame_len();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 5);
            1:       return 6;
            2:       return $urandom_range(20, 40);
            default: return $urandom_range(7, 14);
        endcase
    endfunction

    task automatic send_frame(input int len);
        int i;
        int older;
        int prev;
        int dur;
        older = $urandom_range(0, DUR_MAX);
        prev  = $urandom_range(0, DUR_MAX);
        for (i = 0; i < len; i++)
        begin
            dur = pick_duration(older);
            send_sample(DUR_W'(dur), i == len - 1);
            older = prev;
            prev  = dur;
        end
        sent += len;
    endtask

    initial
    begin
        int i;
        int frames;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_LEN; i++)
            send_sample(DUR_W'(directed_durs[i]), directed_ends[i]);
        wait_drained();

        frames = 0;
        while (sent < RANDOM_SAMPLES)
        begin
            if (sent > RANDOM_SAMPLES - QUIET_TAIL)
            begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_gaps     = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            send_frame(pick_frame_len());
            frames++;
            if (frames % 20 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/ipph_pkg.sv
rtl/ipph_front.sv
rtl/ipph_queue.sv
rtl/ipph_back.sv
rtl/ir_pulse_pattern_hash.sv
test/ir_pulse_pattern_hash_monitor.sv
test/ir_pulse_pattern_hash_tb.sv
